@@ sv/tiled_feature_point_selector_assert.svh @@
// Assertion macros used by the checker in tfps_checker.sv.
`ifndef TILED_FEATURE_POINT_SELECTOR_ASSERT_SVH
`define TILED_FEATURE_POINT_SELECTOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TFPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tfps check failed");

// The consequent must hold in the cycle after the antecedent.
`define TFPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tfps check failed");

`endif

@@ sv/tfps_pkg.sv @@
`default_nettype none
package tfps_pkg;
	localparam logic [2:0] ST_STORED   = 3'd0;
	localparam logic [2:0] ST_BELOW    = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_TOOCLOSE = 3'd3;
	localparam logic [2:0] ST_HALTED   = 3'd4;
	localparam logic [2:0] ST_CLEARED  = 3'd5;
	localparam logic [2:0] ST_OUTGRID  = 3'd6;

	localparam logic [2:0] REG_THRESHOLD  = 3'd0;
	localparam logic [2:0] REG_TILE_SIZE  = 3'd1;
	localparam logic [2:0] REG_SEPARATION = 3'd2;
	localparam logic [2:0] REG_TILES_X    = 3'd3;
	localparam logic [2:0] REG_TILES_Y    = 3'd4;
	localparam logic [2:0] REG_PER_TILE   = 3'd5;
	localparam logic [2:0] REG_LIMIT      = 3'd6;

	localparam logic [13:0] ACC_MAX = 14'h3FFF;
endpackage
`default_nettype wire

@@ sv/tfps_div.sv @@
`default_nettype none
module tfps_div #(
	parameter int DW = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [6:0]    divisor,
	input  wire logic [DW-1:0] dividend [3],
	output logic               done,
	output logic [DW-1:0]      quotient [3]
);
	localparam int CTW = $clog2(DW + 1);

	logic [DW-1:0] a_q [3];
	logic [6:0]    rem_q [3];
	logic [6:0]    div_q;
	logic [CTW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [7:0]    part [3];
	logic [2:0]    ge;
	logic [7:0]    nrem [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			part[i] = {rem_q[i], a_q[i][DW-1]};
			ge[i] = part[i] >= {1'b0, div_q};
			nrem[i] = ge[i] ? part[i] - {1'b0, div_q} : part[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CTW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= divisor;
			for (int i = 0; i < 3; i++) begin
				a_q[i] <= dividend[i];
				rem_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < 3; i++) begin
				a_q[i] <= {a_q[i][DW-2:0], ge[i]};
				rem_q[i] <= nrem[i][6:0];
			end
		end
	end

	assign done = done_q;
	assign quotient = a_q;
endmodule
`default_nettype wire

@@ sv/tfps_dist.sv @@
`default_nettype none
module tfps_dist #(
	parameter int CB = 10
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          valid,
	input  wire logic [CB-1:0] px,
	input  wire logic [CB-1:0] py,
	input  wire logic [CB-1:0] cx,
	input  wire logic [CB-1:0] cy,
	input  wire logic [15:0]   lim,
	output logic               close,
	output logic               close_valid
);
	localparam int SQW = 2 * CB;
	localparam int CMPW = (SQW + 1 > 16) ? SQW + 1 : 16;

	logic signed [CB:0]     dx;
	logic signed [CB:0]     dy;
	logic signed [SQW+1:0]  px2;
	logic signed [SQW+1:0]  py2;
	logic [SQW-1:0] sqx_s1;
	logic [SQW-1:0] sqy_s1;
	logic [15:0]    lim_s1;
	logic           v_s1;
	logic [SQW:0]   sum;
	logic           close_s2;
	logic           v_s2;

	always_comb begin
		dx = $signed({1'b0, px}) - $signed({1'b0, cx});
		dy = $signed({1'b0, py}) - $signed({1'b0, cy});
		px2 = dx * dx;
		py2 = dy * dy;
		sum = {1'b0, sqx_s1} + {1'b0, sqy_s1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		sqx_s1 <= px2[SQW-1:0];
		sqy_s1 <= py2[SQW-1:0];
		lim_s1 <= lim;
		close_s2 <= CMPW'(sum) <= CMPW'(lim_s1);
	end

	assign close = close_s2;
	assign close_valid = v_s2;
endmodule
`default_nettype wire

@@ sv/tiled_feature_point_selector.sv @@
// Tiled feature point selector.
// Input channel (in_valid/in_stall): one transaction per item; mode 0 clears
// the frame, mode 1 offers a candidate with point_x, point_y, response_value.
// Output channel (out_valid/out_stall): one result transaction per item with
// status, accepted_count and tile_index, held in an output register.
// Items are handled one at a time. A candidate passes through the tile
// coordinate divider and the tile index step to the halt, threshold and grid
// checks, and then to a check of its tile's count to see whether it is full.
// One that has room walks the neighbor window, reading the count of each
// tile and each stored point there for the distance check, before it is
// stored or found too close; the tile coordinate divider (one bit a cycle)
// and the single read port of each memory set its pace. A clear item sweeps
// the tile count memory, one tile a cycle, and gives its result at the end.
// After reset the same sweep runs once and in_stall stays high meanwhile;
// configuration writes are taken at any time and should be made while idle.
// When the receiver stalls, the result waits in the output register; the
// next input is still accepted, and its result waits until the register frees.
`default_nettype none
module tiled_feature_point_selector #(
	parameter int MAX_TILES_ACROSS = 128,
	parameter int MAX_TILES_DOWN = 64,
	parameter int MAX_POINTS_PER_TILE = 4,
	parameter int COORD_BITS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        mode,
	input  wire logic [COORD_BITS-1:0] point_x,
	input  wire logic [COORD_BITS-1:0] point_y,
	input  wire logic signed [31:0] response_value,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [13:0]      accepted_count,
	output logic [12:0]      tile_index
);
	import tfps_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int MPT = MAX_POINTS_PER_TILE;
	localparam int NUM_TILES = MAX_TILES_ACROSS * MAX_TILES_DOWN;
	localparam int NUM_SLOTS = NUM_TILES * MPT;
	localparam int TW = NUM_TILES > 1 ? $clog2(NUM_TILES) : 1;
	localparam int SW = NUM_SLOTS > 1 ? $clog2(NUM_SLOTS) : 1;
	localparam int GWW = $clog2(MAX_TILES_ACROSS + 1);
	localparam int GHW = $clog2(MAX_TILES_DOWN + 1);
	localparam int CNTW = $clog2(MPT + 1);
	localparam int DW = CB > 8 ? CB : 8;
	localparam int CW = DW + 1;

	typedef enum logic [15:0] {
		S_IDLE   = 16'h0001,
		S_CLEAR  = 16'h0002,
		S_DIV    = 16'h0004,
		S_TILE   = 16'h0008,
		S_CHK0   = 16'h0010,
		S_CNTCHK = 16'h0020,
		S_WTILE  = 16'h0040,
		S_WRD    = 16'h0080,
		S_WCNT   = 16'h0100,
		S_PRD    = 16'h0200,
		S_PWAIT  = 16'h0400,
		S_PSQ    = 16'h0800,
		S_PCMP   = 16'h1000,
		S_WNEXT  = 16'h2000,
		S_COMMIT = 16'h4000,
		S_DONE   = 16'h8000
	} state_t;

	state_t state_q;

	logic signed [31:0] thr_q;
	logic [6:0]  ts_q;
	logic [7:0]  sep_q;
	logic [7:0]  ta_q;
	logic [6:0]  td_q;
	logic [2:0]  ppt_q;
	logic [12:0] lim_q;

	logic [CB-1:0] x_q;
	logic [CB-1:0] y_q;
	logic signed [31:0] resp_q;
	logic [CB-1:0] tx_q;
	logic [CB-1:0] ty_q;
	logic [7:0]    w_q;
	logic          in_grid_q;
	logic [TW-1:0] tidx_q;
	logic [TW-1:0] sweep_q;
	logic          clr_res_q;
	logic [CW-1:0] x0_q;
	logic [CW-1:0] x1_q;
	logic [CW-1:0] y0_q;
	logic [CW-1:0] y1_q;
	logic [CW-1:0] m_q;
	logic [CW-1:0] n_q;
	logic [TW-1:0] wt_q;
	logic [SW-1:0] base_q;
	logic [SW-1:0] own_base_q;
	logic [CNTW-1:0] own_cnt_q;
	logic [CNTW-1:0] wcnt_q;
	logic [CNTW-1:0] l_q;
	logic [13:0]   acc_q;
	logic          halted_q;
	logic [2:0]    status_q;

	logic          out_valid_q;
	logic [2:0]    out_status_q;
	logic [13:0]   out_acc_q;
	logic [12:0]   out_tidx_q;

	logic [CNTW-1:0] cnt_mem [NUM_TILES];
	logic [CNTW-1:0] cnt_rd_q;
	logic            cnt_re;
	logic [TW-1:0]   cnt_ra;
	logic            cnt_we;
	logic [TW-1:0]   cnt_wa;
	logic [CNTW-1:0] cnt_wd;

	logic [2*CB-1:0] pt_mem [NUM_SLOTS];
	logic [2*CB-1:0] pt_rd_q;
	logic            pt_re;
	logic [SW-1:0]   pt_ra;
	logic            pt_we;
	logic [SW-1:0]   pt_wa;
	logic [2*CB-1:0] pt_wd;

	logic          in_acc;
	logic [6:0]    ts;
	logic [GWW-1:0] gw;
	logic [GHW-1:0] gh;
	logic [CNTW-1:0] cap;
	logic [DW-1:0] div_a [3];
	logic [DW-1:0] div_q [3];
	logic          div_done;
	logic          close;
	logic          close_valid;
	logic [CW-1:0] txe;
	logic [CW-1:0] we;
	logic [CW-1:0] gwe;
	logic [CW-1:0] gue;
	logic [CW-1:0] xs;
	logic [CW-1:0] ys;
	logic [13:0]   acc_n;

	assign in_stall = state_q != S_IDLE;
	assign in_acc = in_valid && !in_stall;
	assign ts = (ts_q == 7'd0) ? 7'd1 : ts_q;
	assign gw = (32'(ta_q) > MAX_TILES_ACROSS) ? GWW'(MAX_TILES_ACROSS) : GWW'(ta_q);
	assign gh = (32'(td_q) > MAX_TILES_DOWN) ? GHW'(MAX_TILES_DOWN) : GHW'(td_q);
	assign cap = (32'(ppt_q) > MPT) ? CNTW'(MPT) : CNTW'(ppt_q);
	assign acc_n = (acc_q < ACC_MAX) ? acc_q + 14'd1 : acc_q;

	assign div_a[0] = DW'(CB'(point_x));
	assign div_a[1] = DW'(CB'(point_y));
	assign div_a[2] = DW'(sep_q);

	tfps_div #(.DW(DW)) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(in_acc && mode),
		.divisor(ts),
		.dividend(div_a),
		.done(div_done),
		.quotient(div_q)
	);

	tfps_dist #(.CB(CB)) u_dist (
		.clk(clk),
		.arst_n(arst_n),
		.valid(state_q == S_PWAIT),
		.px(pt_rd_q[2*CB-1:CB]),
		.py(pt_rd_q[CB-1:0]),
		.cx(x_q),
		.cy(y_q),
		.lim(16'(sep_q) * 16'(sep_q)),
		.close(close),
		.close_valid(close_valid)
	);

	always_comb begin
		txe = CW'(tx_q);
		we = CW'(w_q);
		gwe = CW'(gw);
		gue = CW'(gh);
		xs = CW'(tx_q) + we;
		ys = CW'(ty_q) + we;
		cnt_re = (state_q == S_CHK0) || (state_q == S_WRD);
		cnt_ra = (state_q == S_CHK0) ? tidx_q : wt_q;
		cnt_we = (state_q == S_CLEAR) || (state_q == S_COMMIT);
		cnt_wa = (state_q == S_CLEAR) ? sweep_q : tidx_q;
		cnt_wd = (state_q == S_CLEAR) ? '0 : own_cnt_q + 1'b1;
		pt_re = state_q == S_PRD;
		pt_ra = base_q + SW'(l_q);
		pt_we = state_q == S_COMMIT;
		pt_wa = own_base_q + SW'(own_cnt_q);
		pt_wd = {x_q, y_q};
	end

	always_ff @(posedge clk) begin
		if (cnt_we) begin
			cnt_mem[cnt_wa] <= cnt_wd;
		end
		if (cnt_re) begin
			cnt_rd_q <= cnt_mem[cnt_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (pt_we) begin
			pt_mem[pt_wa] <= pt_wd;
		end
		if (pt_re) begin
			pt_rd_q <= pt_mem[pt_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sweep_q <= '0;
			clr_res_q <= 1'b0;
			acc_q <= '0;
			halted_q <= 1'b0;
			out_valid_q <= 1'b0;
			thr_q <= 32'sd20480;
			ts_q <= 7'd8;
			sep_q <= 8'd8;
			ta_q <= 8'd80;
			td_q <= 7'd60;
			ppt_q <= 3'd1;
			lim_q <= 13'd200;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_THRESHOLD:  thr_q <= cfg_data;
					REG_TILE_SIZE:  ts_q <= cfg_data[6:0];
					REG_SEPARATION: sep_q <= cfg_data[7:0];
					REG_TILES_X:    ta_q <= cfg_data[7:0];
					REG_TILES_Y:    td_q <= cfg_data[6:0];
					REG_PER_TILE:   ppt_q <= cfg_data[2:0];
					REG_LIMIT:      lim_q <= cfg_data[12:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (!mode) begin
							state_q <= S_CLEAR;
							sweep_q <= '0;
							clr_res_q <= 1'b1;
							acc_q <= '0;
							halted_q <= 1'b0;
						end else begin
							x_q <= CB'(point_x);
							y_q <= CB'(point_y);
							resp_q <= response_value;
							state_q <= S_DIV;
						end
					end
				end
				S_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == TW'(NUM_TILES - 1)) begin
						clr_res_q <= 1'b0;
						if (clr_res_q) begin
							status_q <= ST_CLEARED;
							tidx_q <= '0;
							state_q <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						tx_q <= div_q[0][CB-1:0];
						ty_q <= div_q[1][CB-1:0];
						w_q <= div_q[2][7:0];
						state_q <= S_TILE;
					end
				end
				S_TILE: begin
					in_grid_q <= (32'(tx_q) < 32'(gw)) && (32'(ty_q) < 32'(gh));
					if ((32'(tx_q) < 32'(gw)) && (32'(ty_q) < 32'(gh))) begin
						tidx_q <= TW'(32'(ty_q) * 32'(gw) + 32'(tx_q));
					end else begin
						tidx_q <= '0;
					end
					state_q <= S_CHK0;
				end
				S_CHK0: begin
					x0_q <= (txe > we) ? txe - we : '0;
					y0_q <= (CW'(ty_q) > we) ? CW'(ty_q) - we : '0;
					x1_q <= (xs >= gwe) ? gwe - 1'b1 : xs;
					y1_q <= (ys >= gue) ? gue - 1'b1 : ys;
					own_base_q <= SW'(32'(tidx_q) * MPT);
					if (halted_q) begin
						status_q <= ST_HALTED;
						state_q <= S_DONE;
					end else if (resp_q <= thr_q) begin
						status_q <= ST_BELOW;
						state_q <= S_DONE;
					end else if (!in_grid_q) begin
						status_q <= ST_OUTGRID;
						state_q <= S_DONE;
					end else begin
						state_q <= S_CNTCHK;
					end
				end
				S_CNTCHK: begin
					own_cnt_q <= cnt_rd_q;
					if (cnt_rd_q >= cap) begin
						status_q <= ST_FULL;
						state_q <= S_DONE;
					end else begin
						n_q <= y0_q;
						m_q <= x0_q;
						state_q <= S_WTILE;
					end
				end
				S_WTILE: begin
					wt_q <= TW'(32'(n_q) * 32'(gw) + 32'(m_q));
					state_q <= S_WRD;
				end
				S_WRD: begin
					base_q <= SW'(32'(wt_q) * MPT);
					state_q <= S_WCNT;
				end
				S_WCNT: begin
					wcnt_q <= cnt_rd_q;
					l_q <= '0;
					state_q <= (cnt_rd_q == '0) ? S_WNEXT : S_PRD;
				end
				S_PRD: state_q <= S_PWAIT;
				S_PWAIT: state_q <= S_PSQ;
				S_PSQ: state_q <= S_PCMP;
				S_PCMP: begin
					if (close && close_valid) begin
						status_q <= ST_TOOCLOSE;
						state_q <= S_DONE;
					end else if (CNTW'(l_q + 1'b1) < wcnt_q) begin
						l_q <= l_q + 1'b1;
						state_q <= S_PRD;
					end else begin
						state_q <= S_WNEXT;
					end
				end
				S_WNEXT: begin
					if (m_q < x1_q) begin
						m_q <= m_q + 1'b1;
						state_q <= S_WTILE;
					end else if (n_q < y1_q) begin
						n_q <= n_q + 1'b1;
						m_q <= x0_q;
						state_q <= S_WTILE;
					end else begin
						state_q <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					acc_q <= acc_n;
					halted_q <= acc_n > {1'b0, lim_q};
					status_q <= ST_STORED;
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						out_status_q <= status_q;
						out_acc_q <= acc_q;
						out_tidx_q <= 13'(tidx_q);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign accepted_count = out_acc_q;
	assign tile_index = out_tidx_q;
endmodule
`default_nettype wire

@@ sv/tfps_checker.sv @@
`default_nettype none
`include "tiled_feature_point_selector_assert.svh"
module tfps_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [2:0]  status,
	input wire logic [13:0] accepted_count,
	input wire logic [12:0] tile_index
);
	import tfps_pkg::*;

	`TFPS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`TFPS_ASSERT_NEXT(a_busy_after_take, clk, arst_n, in_valid && !in_stall, in_stall)
	`TFPS_ASSERT_SAME(a_clear_zero, clk, arst_n, out_valid && status == ST_CLEARED, accepted_count == 14'd0 && tile_index == 13'd0)
	`TFPS_ASSERT_SAME(a_outgrid_index, clk, arst_n, out_valid && status == ST_OUTGRID, tile_index == 13'd0)
endmodule

bind tiled_feature_point_selector tfps_checker u_tfps_checker (.*);
`default_nettype wire

@@ bench/tb_tiled_feature_point_selector.sv @@
`timescale 1ns / 1ps
module tb_tiled_feature_point_selector;
	import tfps_pkg::*;

	localparam int GRID_X_MAX = 128;
	localparam int GRID_Y_MAX = 64;
	localparam int SLOTS_MAX = 4;
	localparam logic MODE_CLEAR = 1'b0;
	localparam logic MODE_OFFER = 1'b1;

	typedef struct packed {
		logic [2:0]  status;
		logic [13:0] accepted;
		logic [12:0] tile;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = 1'b0;
	logic [9:0] point_x = '0;
	logic [9:0] point_y = '0;
	logic signed [31:0] response_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [13:0] accepted_count;
	logic [12:0] tile_index;

	tiled_feature_point_selector i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .point_x(point_x), .point_y(point_y),
		.response_value(response_value),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .accepted_count(accepted_count), .tile_index(tile_index)
	);

	// Predictor state: configuration and the frame contents.
	logic signed [31:0] thr_q;
	logic [6:0] side_q;
	logic [7:0] sep_q;
	logic [7:0] across_q;
	logic [6:0] down_q;
	logic [2:0] per_tile_q;
	logic [12:0] limit_q;
	logic [2:0] tile_fill [GRID_X_MAX*GRID_Y_MAX];
	logic [9:0] slot_x [GRID_X_MAX*GRID_Y_MAX*SLOTS_MAX];
	logic [9:0] slot_y [GRID_X_MAX*GRID_Y_MAX*SLOTS_MAX];
	logic [13:0] frame_count;
	logic frame_stop;

	verdict_t pending_verdicts[$];
	int errors = 0;
	int stall_pct = 30;
	int gap_max = 4;

	initial forever #6 clk = ~clk;

	initial begin
		#50_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic int eff_side();
		return side_q == 0 ? 1 : side_q;
	endfunction

	function automatic int eff_w();
		return across_q > GRID_X_MAX ? GRID_X_MAX : across_q;
	endfunction

	function automatic int eff_h();
		return down_q > GRID_Y_MAX ? GRID_Y_MAX : down_q;
	endfunction

	function automatic bit near_neighbor(int x, int y, int tx, int ty);
		int gw, gh, w, x0, y0, x1, y1, t;
		longint lim, dx, dy;
		gw = eff_w();
		gh = eff_h();
		w = sep_q / eff_side();
		x0 = tx > w ? tx - w : 0;
		y0 = ty > w ? ty - w : 0;
		x1 = tx + w >= gw ? gw - 1 : tx + w;
		y1 = ty + w >= gh ? gh - 1 : ty + w;
		lim = sep_q * sep_q;
		for (int n = y0; n <= y1; n++)
			for (int m = x0; m <= x1; m++) begin
				t = n * gw + m;
				for (int l = 0; l < tile_fill[t] && l < SLOTS_MAX; l++) begin
					dx = int'(slot_x[t*SLOTS_MAX+l]) - x;
					dy = int'(slot_y[t*SLOTS_MAX+l]) - y;
					if (dx*dx + dy*dy <= lim)
						return 1'b1;
				end
			end
		return 1'b0;
	endfunction

	function automatic verdict_t select_point(logic m, logic [9:0] x, logic [9:0] y,
			logic signed [31:0] r);
		verdict_t v;
		int tx, ty, cap, t;
		bit in_grid;
		if (m == MODE_CLEAR) begin
			foreach (tile_fill[i]) tile_fill[i] = '0;
			frame_count = '0;
			frame_stop = 1'b0;
			v.status = ST_CLEARED;
			v.accepted = '0;
			v.tile = '0;
			return v;
		end
		tx = x / eff_side();
		ty = y / eff_side();
		in_grid = tx < eff_w() && ty < eff_h();
		cap = per_tile_q > SLOTS_MAX ? SLOTS_MAX : per_tile_q;
		t = in_grid ? ty * eff_w() + tx : 0;
		if (frame_stop)
			v.status = ST_HALTED;
		else if (r <= thr_q)
			v.status = ST_BELOW;
		else if (!in_grid)
			v.status = ST_OUTGRID;
		else if (tile_fill[t] >= cap)
			v.status = ST_FULL;
		else if (near_neighbor(x, y, tx, ty))
			v.status = ST_TOOCLOSE;
		else begin
			slot_x[t*SLOTS_MAX+tile_fill[t]] = x;
			slot_y[t*SLOTS_MAX+tile_fill[t]] = y;
			tile_fill[t]++;
			if (frame_count < ACC_MAX)
				frame_count++;
			if (frame_count > limit_q)
				frame_stop = 1'b1;
			v.status = ST_STORED;
		end
		v.accepted = frame_count;
		v.tile = t[12:0];
		return v;
	endfunction

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_THRESHOLD: thr_q = val;
			REG_TILE_SIZE: side_q = val[6:0];
			REG_SEPARATION: sep_q = val[7:0];
			REG_TILES_X: across_q = val[7:0];
			REG_TILES_Y: down_q = val[6:0];
			REG_PER_TILE: per_tile_q = val[2:0];
			REG_LIMIT: limit_q = val[12:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic settle();
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic configure(logic signed [31:0] thr, int side, int sep, int ax, int dy,
			int per, int lim);
		settle();
		write_reg(REG_THRESHOLD, thr);
		write_reg(REG_TILE_SIZE, side);
		write_reg(REG_SEPARATION, sep);
		write_reg(REG_TILES_X, ax);
		write_reg(REG_TILES_Y, dy);
		write_reg(REG_PER_TILE, per);
		write_reg(REG_LIMIT, lim);
	endtask

	task automatic send_item(logic m, logic [9:0] x, logic [9:0] y, logic signed [31:0] r);
		@(negedge clk);
		mode <= m;
		point_x <= x;
		point_y <= y;
		response_value <= r;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pending_verdicts.push_back(select_point(m, x, y, r));
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic send_random(int count, int coord_max, int hi_pct);
		int burst;
		logic [31:0] r;
		while (count > 0) begin
			burst = $urandom_range(1, 12);
			for (int k = 0; k < burst && count > 0; k++, count--) begin
				r = $urandom();
				if ($urandom_range(0, 99) < hi_pct)
					r = $urandom_range(20481, 2_000_000);
				send_item($urandom_range(0, 60) == 0 ? MODE_CLEAR : MODE_OFFER,
					10'($urandom_range(0, coord_max)),
					10'($urandom_range(0, coord_max)), r);
			end
			if ($urandom_range(0, 3) != 0)
				repeat ($urandom_range(1, gap_max)) @(negedge clk);
		end
	endtask

	always @(negedge clk)
		out_stall <= ($urandom_range(0, 99) < stall_pct);

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result status=%0d count=%0d tile=%0d",
					$time, status, accepted_count, tile_index);
				errors++;
			end else begin
				want = pending_verdicts.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					errors++;
				end
				if (accepted_count !== want.accepted) begin
					$display("%0t: accepted_count expected %0d actual %0d", $time,
						want.accepted, accepted_count);
					errors++;
				end
				if (tile_index !== want.tile) begin
					$display("%0t: tile_index expected %0d actual %0d", $time,
						want.tile, tile_index);
					errors++;
				end
			end
		end
	end

	task automatic test_reset_defaults();
		@(negedge clk);
		send_item(MODE_OFFER, 10'd0, 10'd0, 32'sd20481);
		send_item(MODE_OFFER, 10'd4, 10'd4, 32'sd20480);
		send_item(MODE_OFFER, 10'd3, 10'd3, 32'sd30000);
		send_item(MODE_OFFER, 10'd20, 10'd0, 32'sd30000);
		send_item(MODE_OFFER, 10'd1023, 10'd1023, 32'sh7FFFFFFF);
		send_item(MODE_OFFER, 10'd1023, 10'd0, 32'sh80000000);
		send_item(MODE_OFFER, 10'd639, 10'd479, 32'sd99999);
		send_item(MODE_CLEAR, 10'h3FF, 10'h3FF, 32'shFFFFFFFF);
		send_item(MODE_OFFER, 10'd0, 10'd0, 32'sd20481);
	endtask

	task automatic test_extremes();
		configure(32'sh80000000, 1, 0, 128, 64, 4, 2);
		send_item(MODE_OFFER, 10'd5, 10'd5, 32'sh80000001);
		send_item(MODE_OFFER, 10'd5, 10'd5, 32'sd1);
		send_item(MODE_OFFER, 10'd6, 10'd5, 32'sd1);
		send_item(MODE_OFFER, 10'd7, 10'd5, 32'sd1);
		send_item(MODE_OFFER, 10'd8, 10'd5, 32'sd1);
		send_item(MODE_OFFER, 10'd200, 10'd5, 32'sd1);
		configure(32'sh7FFFFFFF, 0, 255, 255, 127, 7, 8191);
		send_item(MODE_CLEAR, 10'd0, 10'd0, 32'sd0);
		send_item(MODE_OFFER, 10'd1, 10'd1, 32'sh7FFFFFFF);
		configure(32'sd0, 64, 255, 0, 1, 0, 0);
		send_item(MODE_OFFER, 10'd1, 10'd1, 32'sd5);
		configure(32'sd0, 64, 255, 16, 16, 0, 0);
		send_item(MODE_OFFER, 10'd1, 10'd1, 32'sd5);
		configure(32'sd0, 64, 255, 16, 16, 4, 0);
		send_item(MODE_OFFER, 10'd1, 10'd1, 32'sd5);
		send_item(MODE_OFFER, 10'd1000, 10'd1000, 32'sd5);
		send_item(MODE_CLEAR, 10'd0, 10'd0, 32'sd0);
		send_item(MODE_OFFER, 10'd1000, 10'd1000, 32'sd5);
	endtask

	task automatic test_dense_frames();
		configure(32'sd20480, 8, 8, 80, 60, 1, 200);
		send_random(200, 639, 80);
		configure(32'sd1000, 4, 3, 128, 64, 4, 8191);
		send_random(200, 511, 85);
		configure(-32'sd5, 16, 20, 40, 30, 2, 25);
		send_random(150, 700, 70);
	endtask

	task automatic test_quiet_pause();
		settle();
		stall_pct = 0;
		gap_max = 1;
		configure(32'sd0, 2, 1, 128, 64, 3, 60);
		send_random(100, 255, 90);
		settle();
		stall_pct = 80;
		gap_max = 10;
		send_random(100, 1023, 60);
		stall_pct = 30;
		gap_max = 4;
	endtask

	initial begin
		thr_q = 32'sd20480;
		side_q = 7'd8;
		sep_q = 8'd8;
		across_q = 8'd80;
		down_q = 7'd60;
		per_tile_q = 3'd1;
		limit_q = 13'd200;
		foreach (tile_fill[i]) tile_fill[i] = '0;
		frame_count = '0;
		frame_stop = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_extremes();
		test_dense_frames();
		test_quiet_pause();
		settle();
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
